// ===== hdl/cascaded_pid_motor_current_assert.svh =====
// assertion macros used by the rtl module
`ifndef CASCADED_PID_MOTOR_CURRENT_ASSERT_SVH
`define CASCADED_PID_MOTOR_CURRENT_ASSERT_SVH

// property checked at every clock edge, held off during reset
`define CPMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every clock edge, reset included
`define CPMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpmc_pkg
// Constants, register indexes and saturation helpers for the motor current
// controller.
// ----------------------------------------------------------------------------
package cpmc_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int MOT_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int OUT_FIELDS = 4;

  localparam logic [10:0] FIRST_ID = 11'h201;
  localparam int          CUR_LIMIT = 10000;

  localparam int ACC_W = 52;

  // configuration register indexes
  localparam logic [2:0] REG_CONTROL_MODE = 3'd0;
  localparam logic [2:0] REG_SPEED_KP     = 3'd1;
  localparam logic [2:0] REG_SPEED_KI_DT  = 3'd2;
  localparam logic [2:0] REG_SPEED_KD_DT  = 3'd3;
  localparam logic [2:0] REG_POS_KP       = 3'd4;
  localparam logic [2:0] REG_POS_KI_DT    = 3'd5;
  localparam logic [2:0] REG_POS_KD_DT    = 3'd6;
  localparam logic [2:0] REG_TARGET       = 3'd7;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [31:0]      q32_t;

  // saturate a wide signed value to 32 bits
  function automatic q32_t sat32(acc_t v);
    acc_t hi;
    acc_t lo;
    hi = acc_t'(64'sd2147483647);
    lo = -acc_t'(64'sd2147483648);
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== hdl/cascaded_pid_motor_current.sv =====
// ----------------------------------------------------------------------------
// cascaded_pid_motor_current
// Cascaded position and speed pid, or speed pid alone, producing four clamped drive currents.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel (valid/ready): mode 0 is a feedback frame, mode 1 a control
//   tick. A frame with id 0x201..0x200+NUM_MOTORS stores that motor's encoder
//   count and speed; other ids are dropped. A frame never gives a result.
//   A tick runs the loops motor by motor through a shared 16x33 multiplier:
//   in position mode each motor goes through read, position error, three
//   position products, speed error, three speed products and write back;
//   speed mode skips the three position products. The loop state per motor
//   lives in a memory with registered read data; each entry is read, updated
//   and written back once per tick.
//   out_* channel (valid/ready): one transfer per tick with the four
//   currents. A stalled receiver holds the result; a new item is taken while
//   it waits, and a following tick waits at its end for the output register.
//   cfg_* channel: always ready, index 0..7 in register order; write only
//   while idle.
//   Reset restores register defaults and marks all stored state as zero.
// ----------------------------------------------------------------------------
module cascaded_pid_motor_current (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [10:0]        in_frame_id,
  input  logic [15:0]        in_encoder_count,
  input  logic signed [15:0] in_speed_rpm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_current_motor_0,
  output logic signed [14:0] out_current_motor_1,
  output logic signed [14:0] out_current_motor_2,
  output logic signed [14:0] out_current_motor_3,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_addr,
  input  logic [23:0]        cfg_data
);
  import cpmc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_ERR_P = 4'd2;
  localparam logic [3:0] S_MP0   = 4'd3;
  localparam logic [3:0] S_MP1   = 4'd4;
  localparam logic [3:0] S_MP2   = 4'd5;
  localparam logic [3:0] S_ERR_S = 4'd6;
  localparam logic [3:0] S_MS0   = 4'd7;
  localparam logic [3:0] S_MS1   = 4'd8;
  localparam logic [3:0] S_MS2   = 4'd9;
  localparam logic [3:0] S_WB    = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // configuration registers
  logic               casc_r;
  logic signed [15:0] skp_r, ski_r, skd_r, pkp_r, pki_r, pkd_r;
  logic signed [23:0] tgt_r;

  // memories: feedback {encoder, speed} and loop state {pi, pp, si, sp}
  logic [31:0]  fb_mem [NUM_MOTORS];
  logic [127:0] st_mem [NUM_MOTORS];
  logic [31:0]  fb_rd_r;
  logic [127:0] st_rd_r;
  logic [NUM_MOTORS-1:0] fb_vld_r, st_vld_r;
  logic         fb_rv_r, st_rv_r;

  logic [3:0]       state_r;
  logic [MOT_W-1:0] mot_r;

  logic signed [32:0] e_r, i_r, d_r;
  q32_t npi_r, npp_r, nsi_r, nsp_r;
  acc_t acc_r;

  logic signed [14:0] cur_r [OUT_FIELDS];
  logic signed [14:0] out_r [OUT_FIELDS];
  logic               out_valid_r;

  logic in_fire, fb_hit;
  logic [10:0] id_off;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign id_off    = in_frame_id - FIRST_ID;
  assign fb_hit    = (in_frame_id >= FIRST_ID) &&
                     ({21'd0, id_off} < 32'(NUM_MOTORS));

  // stored values, zero where an entry was never written
  logic [15:0]        enc;
  logic signed [15:0] spd;
  q32_t pi_old, pp_old, si_old, sp_old;
  assign enc    = fb_rv_r ? fb_rd_r[31:16] : 16'd0;
  assign spd    = fb_rv_r ? fb_rd_r[15:0]  : 16'sd0;
  assign pi_old = st_rv_r ? st_rd_r[127:96] : 32'sd0;
  assign pp_old = st_rv_r ? st_rd_r[95:64]  : 32'sd0;
  assign si_old = st_rv_r ? st_rd_r[63:32]  : 32'sd0;
  assign sp_old = st_rv_r ? st_rd_r[31:0]   : 32'sd0;

  // position error: angle in q8 degrees is floor(count*45/4)
  logic [21:0] ang;
  q32_t tgt32, ep, ip;
  acc_t ip_sum;
  assign ang    = 22'(({6'd0, enc} * 22'd45) >> 2);
  assign tgt32  = {{8{tgt_r[23]}}, tgt_r};
  assign ep     = tgt32 - signed'({10'd0, ang});
  assign ip_sum = acc_t'(pi_old) + acc_t'(ep);
  assign ip     = sat32(ip_sum);

  // speed setpoint: position output truncated toward zero, or target
  acc_t acc_rnd, cur_rnd;
  q32_t sp_sel, es, is;
  acc_t es_sum, is_sum;
  logic signed [23:0] meas;
  assign acc_rnd = (acc_r + (acc_r[ACC_W-1] ? acc_t'(255) : acc_t'(0))) >>> 8;
  assign sp_sel  = casc_r ? sat32(acc_rnd) : tgt32;
  assign meas    = {spd, 8'd0};
  assign es_sum  = acc_t'(sp_sel) - acc_t'(meas);
  assign es      = sat32(es_sum);
  assign is_sum  = acc_t'(si_old) + acc_t'(es);
  assign is      = sat32(is_sum);

  // current: truncate toward zero, clamp
  logic signed [14:0] cur_clamp;
  assign cur_rnd = (acc_r + (acc_r[ACC_W-1] ? acc_t'(65535) : acc_t'(0))) >>> 16;
  always_comb begin
    if (cur_rnd > acc_t'(CUR_LIMIT)) begin
      cur_clamp = 15'(CUR_LIMIT);
    end else if (cur_rnd < -acc_t'(CUR_LIMIT)) begin
      cur_clamp = -15'(CUR_LIMIT);
    end else begin
      cur_clamp = cur_rnd[14:0];
    end
  end

  // shared multiplier, operands by step
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] prod;
  logic               acc_first;
  always_comb begin
    acc_first = 1'b0;
    case (state_r)
      S_MP0:   begin mul_a = pkp_r; mul_b = e_r; acc_first = 1'b1; end
      S_MP1:   begin mul_a = pki_r; mul_b = i_r; end
      S_MP2:   begin mul_a = pkd_r; mul_b = d_r; end
      S_MS0:   begin mul_a = skp_r; mul_b = e_r; acc_first = 1'b1; end
      S_MS1:   begin mul_a = ski_r; mul_b = i_r; end
      S_MS2:   begin mul_a = skd_r; mul_b = d_r; end
      default: begin mul_a = 16'sd0; mul_b = 33'sd0; end
    endcase
  end
  assign prod = mul_a * mul_b;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      casc_r <= 1'b1;
      skp_r  <= 16'sd512;
      ski_r  <= 16'sd51;
      skd_r  <= 16'sd0;
      pkp_r  <= 16'sd256;
      pki_r  <= 16'sd0;
      pkd_r  <= 16'sd512;
      tgt_r  <= 24'sd25600;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_CONTROL_MODE: casc_r <= cfg_data[0];
        REG_SPEED_KP:     skp_r  <= cfg_data[15:0];
        REG_SPEED_KI_DT:  ski_r  <= cfg_data[15:0];
        REG_SPEED_KD_DT:  skd_r  <= cfg_data[15:0];
        REG_POS_KP:       pkp_r  <= cfg_data[15:0];
        REG_POS_KI_DT:    pki_r  <= cfg_data[15:0];
        REG_POS_KD_DT:    pkd_r  <= cfg_data[15:0];
        REG_TARGET:       tgt_r  <= cfg_data;
        default:          casc_r <= casc_r;
      endcase
    end
  end

  // memory ports: frame write, write back, one read per cycle
  always_ff @(posedge clk) begin
    if (in_fire && !in_mode && fb_hit) begin
      fb_mem[id_off[MOT_W-1:0]] <= {in_encoder_count, in_speed_rpm};
    end
    if (state_r == S_WB) begin
      st_mem[mot_r] <= {npi_r, npp_r, nsi_r, nsp_r};
    end
    fb_rd_r <= fb_mem[mot_r];
    st_rd_r <= st_mem[mot_r];
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_vld_r <= '0;
      st_vld_r <= '0;
      fb_rv_r  <= 1'b0;
      st_rv_r  <= 1'b0;
    end else begin
      if (in_fire && !in_mode && fb_hit) begin
        fb_vld_r[id_off[MOT_W-1:0]] <= 1'b1;
      end
      if (state_r == S_WB) begin
        st_vld_r[mot_r] <= 1'b1;
      end
      fb_rv_r <= fb_vld_r[mot_r];
      st_rv_r <= st_vld_r[mot_r];
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_mode) begin
            mot_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD:  state_r <= S_ERR_P;
        S_ERR_P: state_r <= casc_r ? S_MP0 : S_ERR_S;
        S_MP0: state_r <= S_MP1;
        S_MP1: state_r <= S_MP2;
        S_MP2: state_r <= S_ERR_S;
        S_ERR_S: state_r <= S_MS0;
        S_MS0: state_r <= S_MS1;
        S_MS1: state_r <= S_MS2;
        S_MS2: state_r <= S_WB;
        S_WB: begin
          if (32'(mot_r) == NUM_MOTORS - 1) begin
            state_r <= S_DONE;
          end else begin
            mot_r   <= mot_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_mode) begin
          for (int k = 0; k < OUT_FIELDS; k++) cur_r[k] <= 15'sd0;
        end
      end
      S_ERR_P: begin
        if (casc_r) begin
          e_r   <= 33'(ep);
          i_r   <= 33'(ip);
          d_r   <= 33'(ep) - 33'(pp_old);
          npi_r <= ip;
          npp_r <= ep;
        end else begin
          npi_r <= pi_old;
          npp_r <= pp_old;
        end
      end
      S_ERR_S: begin
        e_r   <= 33'(es);
        i_r   <= 33'(is);
        d_r   <= 33'(es) - 33'(sp_old);
        nsi_r <= is;
        nsp_r <= es;
      end
      S_MP0, S_MP1, S_MP2, S_MS0, S_MS1, S_MS2: begin
        acc_r <= (acc_first ? acc_t'(0) : acc_r) + acc_t'(prod);
      end
      S_WB: begin
        for (int k = 0; k < OUT_FIELDS; k++) begin
          if (32'(mot_r) == k) cur_r[k] <= cur_clamp;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          for (int k = 0; k < OUT_FIELDS; k++) out_r[k] <= cur_r[k];
        end
      end
      default: acc_r <= acc_r;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_current_motor_0 = out_r[0];
  assign out_current_motor_1 = out_r[1];
  assign out_current_motor_2 = out_r[2];
  assign out_current_motor_3 = out_r[3];

  // checks
  `include "cascaded_pid_motor_current_assert.svh"

  `CPMC_ASSERT(a_tick_starts, in_fire && in_mode |=> state_r == S_RD, "tick not started")
  `CPMC_ASSERT(a_frame_no_result, in_fire && !in_mode && !out_valid_r |=> !out_valid_r, "frame gave result")
  `CPMC_ASSERT(a_out_hold, out_valid_r && !out_ready |=> out_valid_r && $stable(out_r[0]), "result lost while stalled")
  `CPMC_ASSERT(a_cur_range, out_valid_r |-> out_r[0] <= 15'sd10000 && out_r[0] >= -15'sd10000, "current out of range")
  `CPMC_ASSERT(a_motor_range, state_r != S_IDLE |-> 32'(mot_r) < NUM_MOTORS, "motor index out of range")

endmodule

// ===== tb/sv/cascaded_pid_motor_current_test.sv =====
// ----------------------------------------------------------------------------
// cascaded_pid_motor_current_test
// Self-checking testbench: writes registers, feeds feedback frames and control
// ticks, predicts each drive current with a cycle-free copy of the pid cascade
// and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cascaded_pid_motor_current_test;
  import cpmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int NMOT           = 4;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [10:0]        in_frame_id;
  logic [15:0]        in_encoder_count;
  logic signed [15:0] in_speed_rpm;
  logic               out_valid;
  logic               out_ready;
  logic signed [14:0] out_current_motor_0;
  logic signed [14:0] out_current_motor_1;
  logic signed [14:0] out_current_motor_2;
  logic signed [14:0] out_current_motor_3;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_addr;
  logic [23:0]        cfg_data;

  cascaded_pid_motor_current dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_frame_id(in_frame_id), .in_encoder_count(in_encoder_count),
    .in_speed_rpm(in_speed_rpm),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_current_motor_0(out_current_motor_0),
    .out_current_motor_1(out_current_motor_1),
    .out_current_motor_2(out_current_motor_2),
    .out_current_motor_3(out_current_motor_3),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic signed [14:0] c0;
    logic signed [14:0] c1;
    logic signed [14:0] c2;
    logic signed [14:0] c3;
  } currents_t;

  // predictor state
  logic [23:0]        reg_shadow [8];
  logic [15:0]        enc_shadow [NMOT];
  logic signed [15:0] spd_shadow [NMOT];
  q32_t               pos_int [NMOT];
  q32_t               pos_prev [NMOT];
  q32_t               spd_int [NMOT];
  q32_t               spd_prev [NMOT];

  currents_t expected_currents[$];
  int        error_count;
  int        idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_q32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one loop update; returns exact Q16 accumulator
  function automatic longint pid_update(longint sp, longint meas, longint kp,
                                        longint ki, longint kd,
                                        inout q32_t integ, inout q32_t prev);
    longint e;
    longint d;
    e = clamp_q32(sp - meas);
    d = e - longint'(prev);
    integ = q32_t'(clamp_q32(longint'(integ) + e));
    prev = q32_t'(e);
    return kp * e + ki * longint'(integ) + kd * d;
  endfunction

  // predicted effect of one accepted item
  task automatic predict_currents(logic mode, logic [10:0] id, logic [15:0] enc,
                                  logic signed [15:0] spd);
    longint skp, ski, skd, pkp, pki, pkd, tgt, sp, acc, cur, ang;
    logic signed [14:0] res [NMOT];
    currents_t r;
    if (mode == 1'b0) begin
      if (id >= FIRST_ID && id < FIRST_ID + NMOT) begin
        enc_shadow[id - FIRST_ID] = enc;
        spd_shadow[id - FIRST_ID] = spd;
      end
      return;
    end
    skp = longint'($signed(reg_shadow[REG_SPEED_KP][15:0]));
    ski = longint'($signed(reg_shadow[REG_SPEED_KI_DT][15:0]));
    skd = longint'($signed(reg_shadow[REG_SPEED_KD_DT][15:0]));
    pkp = longint'($signed(reg_shadow[REG_POS_KP][15:0]));
    pki = longint'($signed(reg_shadow[REG_POS_KI_DT][15:0]));
    pkd = longint'($signed(reg_shadow[REG_POS_KD_DT][15:0]));
    tgt = longint'($signed(reg_shadow[REG_TARGET][23:0]));
    for (int m = 0; m < NMOT; m++) begin
      sp = tgt;
      if (reg_shadow[REG_CONTROL_MODE][0]) begin
        ang = (longint'(enc_shadow[m]) * 45) / 4;
        acc = pid_update(tgt, ang, pkp, pki, pkd, pos_int[m], pos_prev[m]);
        sp = clamp_q32(acc / 256);
      end
      acc = pid_update(sp, longint'(spd_shadow[m]) * 256, skp, ski, skd,
                       spd_int[m], spd_prev[m]);
      cur = acc / 65536;
      if (cur > CUR_LIMIT) cur = CUR_LIMIT;
      if (cur < -CUR_LIMIT) cur = -CUR_LIMIT;
      res[m] = cur[14:0];
    end
    r.c0 = res[0];
    r.c1 = res[1];
    r.c2 = res[2];
    r.c3 = res[3];
    expected_currents.push_back(r);
  endtask

  // send one item and wait for its transfer
  task automatic send_item(logic mode, logic [10:0] id, logic [15:0] enc,
                           logic signed [15:0] spd);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_frame_id      <= id;
    in_encoder_count <= enc;
    in_speed_rpm     <= spd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_currents(mode, id, enc, spd);
  endtask

  task automatic send_tick();
    send_item(1'b1, 11'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // register write while idle
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_CONTROL_MODE) reg_shadow[idx] = {23'd0, val[0]};
    else if (idx == REG_TARGET) reg_shadow[idx] = val;
    else reg_shadow[idx] = {8'd0, val[15:0]};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_currents.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_gains(logic [15:0] skp, logic [15:0] ski, logic [15:0] skd,
                            logic [15:0] pkp, logic [15:0] pki, logic [15:0] pkd);
    write_reg(REG_SPEED_KP, {8'd0, skp});
    write_reg(REG_SPEED_KI_DT, {8'd0, ski});
    write_reg(REG_SPEED_KD_DT, {8'd0, skd});
    write_reg(REG_POS_KP, {8'd0, pkp});
    write_reg(REG_POS_KI_DT, {8'd0, pki});
    write_reg(REG_POS_KD_DT, {8'd0, pkd});
  endtask

  // result checker, with a drawn wait before each transfer
  initial begin
    currents_t e;
    int wait_cnt;
    out_ready = 1'b0;
    wait_cnt  = $urandom_range(0, 6);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_currents.size() == 0) begin
          $display("%0t: unexpected result %0d %0d %0d %0d", $time,
                   out_current_motor_0, out_current_motor_1,
                   out_current_motor_2, out_current_motor_3);
          error_count++;
        end else begin
          e = expected_currents.pop_front();
          if (out_current_motor_0 !== e.c0 || out_current_motor_1 !== e.c1 ||
              out_current_motor_2 !== e.c2 || out_current_motor_3 !== e.c3) begin
            $display("%0t: current mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                     $time, e.c0, e.c1, e.c2, e.c3, out_current_motor_0,
                     out_current_motor_1, out_current_motor_2, out_current_motor_3);
            error_count++;
          end
        end
        wait_cnt = $urandom_range(0, 6);
        out_ready <= (wait_cnt == 0);
      end else if (!out_ready) begin
        if (wait_cnt > 0) wait_cnt--;
        if (wait_cnt == 0) out_ready <= 1'b1;
      end
    end
  end

  // watchdog on transfer activity
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // directed extremes of fields and frame ids
  task automatic test_directed();
    send_tick();
    send_item(1'b0, 11'h201, 16'hffff, 16'sh7fff);
    send_item(1'b0, 11'h202, 16'h0000, 16'sh8000);
    send_item(1'b0, 11'h203, 16'h1234, -16'sd500);
    send_item(1'b0, 11'h204, 16'h8000, 16'sd1200);
    send_item(1'b0, 11'h200, 16'h5555, 16'sh1111);
    send_item(1'b0, 11'h205, 16'haaaa, 16'sh2222);
    send_item(1'b0, 11'h7ff, 16'hffff, 16'shffff);
    send_item(1'b0, 11'h000, 16'h0000, 16'sh0000);
    repeat (4) send_tick();
  endtask

  // speed loop only, extreme gains and targets
  task automatic test_speed_mode();
    write_reg(REG_CONTROL_MODE, 24'd0);
    load_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    write_reg(REG_TARGET, 24'h7fffff);
    repeat (3) send_tick();
    write_reg(REG_TARGET, 24'h800000);
    repeat (3) send_tick();
    load_gains(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
    repeat (3) send_tick();
  endtask

  // random frames and ticks under one setting
  task automatic random_phase(int n);
    logic [10:0] id;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_tick();
      end else begin
        id = ($urandom_range(0, 7) == 0) ? 11'($urandom) :
             11'(FIRST_ID + $urandom_range(0, NMOT - 1));
        send_item(1'b0, id, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic test_random();
    logic [15:0] g [6];
    for (int p = 0; p < 8; p++) begin
      for (int k = 0; k < 6; k++)
        g[k] = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
               16'($signed(16'($urandom_range(0, 1024))) - 16'sd512);
      write_reg(REG_CONTROL_MODE, 24'($urandom_range(0, 1)));
      load_gains(g[0], g[1], g[2], g[3], g[4], g[5]);
      write_reg(REG_TARGET, ($urandom_range(0, 2) == 0) ? 24'($urandom) :
                24'($signed(24'($urandom_range(0, 200000))) - 24'sd100000));
      random_phase(100);
    end
    write_reg(REG_CONTROL_MODE, 24'd1);
    load_gains(16'd512, 16'd51, 16'd0, 16'd256, 16'd0, 16'd512);
    write_reg(REG_TARGET, 24'd25600);
    random_phase(50);
  endtask

  // stimulus sequence
  initial begin
    error_count      = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = 1'b0;
    in_frame_id      = '0;
    in_encoder_count = '0;
    in_speed_rpm     = '0;
    cfg_valid        = 1'b0;
    cfg_addr         = '0;
    cfg_data         = '0;
    reg_shadow[0] = 24'd1;   reg_shadow[1] = 24'd512;
    reg_shadow[2] = 24'd51;  reg_shadow[3] = 24'd0;
    reg_shadow[4] = 24'd256; reg_shadow[5] = 24'd0;
    reg_shadow[6] = 24'd512; reg_shadow[7] = 24'd25600;
    for (int m = 0; m < NMOT; m++) begin
      enc_shadow[m] = '0; spd_shadow[m] = '0;
      pos_int[m] = '0; pos_prev[m] = '0; spd_int[m] = '0; spd_prev[m] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_speed_mode();
    test_random();
    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
